FILE: rtl/btpc_pkg.sv
// btpc_pkg: shared types, widths and constants of the pressure/temperature
// compensation block. Used by every module of the block; depends on nothing.
package btpc_pkg;

   // field widths
   localparam int RAW_W  = 20;
   localparam int TEMP_W = 16;
   localparam int PRES_W = 25;
   localparam int CAL_W  = 16;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_TEMP    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_PRESS_A = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_PRESS_B = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALIB_PRESS_C = 2'd3;

   // datapath widths
   localparam int D_W    = 21;   // at - 16*T1
   localparam int N_W    = 58;   // temperature sum numerator
   localparam int TQ_W   = 21;   // rounded temperature before saturation
   localparam int U_W    = 24;   // truncated temperature minus offset
   localparam int POLY_W = 62;   // D, E, F terms
   localparam int MAG_W  = 61;   // magnitudes of D and F
   localparam int NUM_W  = 74;   // |F| * 6250
   localparam int DEN_W  = 77;   // P1 * |D|
   localparam int NUM_SHIFT = 40;
   localparam int Q_W    = 47;   // quotient magnitude
   localparam int QS_W   = 48;   // signed quotient
   localparam int REM_W  = 124;  // divider remainder
   localparam int SQ_W   = 94;   // quotient squared
   localparam int Z_W    = 112;  // final pressure polynomial
   localparam int Z_SHIFT = 59;

   localparam logic signed [TQ_W-1:0]  TEMP_OFFSET = 21'sd3200;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 16'sh7FFF;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN   = 16'sh8000;
   localparam logic [U_W-1:0]  U_OFFSET  = 24'd128000;
   localparam logic [13:0]     PRES_SCALE = 14'd6250;
   localparam logic [Q_W-1:0]  Q_MAX     = {Q_W{1'b1}};
   localparam logic [PRES_W-1:0] PRES_MAX = {PRES_W{1'b1}};
   localparam logic [Z_W-1:0]  Z_HALF    = Z_W'(1) << (Z_SHIFT - 1);

   typedef struct packed {
      logic [CAL_W-1:0] t1;
      logic [CAL_W-1:0] t2;
      logic [CAL_W-1:0] t3;
      logic [CAL_W-1:0] p1;
      logic [CAL_W-1:0] p2;
      logic [CAL_W-1:0] p3;
      logic [CAL_W-1:0] p4;
      logic [CAL_W-1:0] p5;
      logic [CAL_W-1:0] p6;
      logic [CAL_W-1:0] p7;
      logic [CAL_W-1:0] p8;
      logic [CAL_W-1:0] p9;
   } calib_type;

   // front end result, one queue entry
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     tflag;
      logic [NUM_W-1:0]         nm;
      logic [DEN_W-1:0]         den;
      logic                     neg;
      logic                     zero;
   } front_rec_type;

   // side data travelling with the divider and the pressure polynomial
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic                     tflag;
      logic                     neg;
      logic                     ovf;
      logic                     zero;
   } side_type;

endpackage

FILE: rtl/btpc_front.sv
// btpc_front: 12-stage front pipeline. Temperature result and the numerator
// and divisor of the intermediate pressure. Depends on btpc_pkg.
module btpc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  btpc_pkg::calib_type            calib,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [btpc_pkg::RAW_W-1:0]     req_raw_pressure,
   input  logic [btpc_pkg::RAW_W-1:0]     req_raw_temperature,
   input  logic                           queue_full,
   output logic                           push,
   output btpc_pkg::front_rec_type        push_data
);

   localparam int STAGES = 12;

   logic [STAGES-1:0] v_ff;
   logic              en;

   logic [btpc_pkg::RAW_W-1:0]            ap_ff [1:8];
   logic signed [btpc_pkg::TEMP_W-1:0]    temp_ff [6:12];
   logic                                  tflag_ff [6:12];

   logic signed [btpc_pkg::D_W-1:0]       d1_ff;
   logic signed [36:0]                    m1_2_ff, m1_3_ff;
   logic signed [41:0]                    m2_2_ff;
   logic signed [btpc_pkg::N_W-1:0]       m3_3_ff;
   logic signed [btpc_pkg::N_W-1:0]       n4_ff;
   logic signed [btpc_pkg::TQ_W-1:0]      tq5_ff;
   logic signed [btpc_pkg::U_W-1:0]       u5_ff;
   logic signed [47:0]                    uu6_ff;
   logic signed [39:0]                    pu2_6_ff, pu5_6_ff, pu2_7_ff, pu5_7_ff;
   logic signed [63:0]                    a3_7_ff, a6_7_ff;
   logic signed [btpc_pkg::POLY_W-1:0]    dd8_ff, e8_ff, dd9_ff, f9_ff;
   logic [btpc_pkg::MAG_W-1:0]            fm10_ff, ddm10_ff;
   logic                                  neg10_ff, neg11_ff, neg12_ff;
   logic [47:0]                           pl11_ff;
   logic [44:0]                           ph11_ff, nl11_ff;
   logic [41:0]                           nh11_ff;
   logic                                  zero11_ff, zero12_ff;
   logic [btpc_pkg::DEN_W-1:0]            den12_ff;
   logic [btpc_pkg::NUM_W-1:0]            nm12_ff;

   logic signed [btpc_pkg::D_W-1:0]       d1_in;
   logic signed [63:0]                    n9_in;
   logic                                  tf_fix;
   logic signed [btpc_pkg::U_W-1:0]       u5_in;
   logic signed [btpc_pkg::TEMP_W-1:0]    temp6_in;
   logic                                  tflag6_in;
   logic [btpc_pkg::D_W-1:0]              gap_in;
   logic signed [btpc_pkg::POLY_W-1:0]    f9_in;

   // stall only when the last stage holds an item the queue cannot take
   assign en        = !v_ff[STAGES-1] || !queue_full;
   assign req_ready = en;
   assign push      = v_ff[STAGES-1] && !queue_full;

   assign d1_in  = {1'b0, req_raw_temperature} - {1'b0, calib.t1, 4'b0000};
   assign n9_in  = (64'(n4_ff) <<< 3) + 64'(n4_ff) + (64'sd1 <<< 41);
   assign tf_fix = n4_ff[btpc_pkg::N_W-1] && (n4_ff[33:0] != '0);
   assign u5_in  = btpc_pkg::U_W'(n4_ff >>> 34) + {{(btpc_pkg::U_W-1){1'b0}}, tf_fix}
                   - btpc_pkg::U_OFFSET;
   assign gap_in = btpc_pkg::D_W'(21'h100000) - {1'b0, ap_ff[8]};
   assign f9_in  = ($signed({{(btpc_pkg::POLY_W-btpc_pkg::D_W){1'b0}}, gap_in}) <<< 31)
                   - e8_ff;

   always_comb begin
      tflag6_in = 1'b0;
      temp6_in  = btpc_pkg::TEMP_W'(tq5_ff);
      if (tq5_ff > btpc_pkg::TQ_W'(btpc_pkg::TEMP_MAX)) begin
         temp6_in  = btpc_pkg::TEMP_MAX;
         tflag6_in = 1'b1;
      end else if (tq5_ff < btpc_pkg::TQ_W'(btpc_pkg::TEMP_MIN)) begin
         temp6_in  = btpc_pkg::TEMP_MIN;
         tflag6_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ap_ff[1] <= req_raw_pressure;
         for (int i = 2; i <= 8; i++) ap_ff[i] <= ap_ff[i-1];
         temp_ff[6]  <= temp6_in;
         tflag_ff[6] <= tflag6_in;
         for (int i = 7; i <= 12; i++) begin
            temp_ff[i]  <= temp_ff[i-1];
            tflag_ff[i] <= tflag_ff[i-1];
         end
         // temperature polynomial
         d1_ff   <= d1_in;
         m1_2_ff <= d1_ff * $signed(calib.t2);
         m2_2_ff <= d1_ff * d1_ff;
         m1_3_ff <= m1_2_ff;
         m3_3_ff <= m2_2_ff * $signed(calib.t3);
         n4_ff   <= (btpc_pkg::N_W'(m1_3_ff) <<< 20) + m3_3_ff;
         // rounded 0.01 degF and truncated offset temperature
         tq5_ff  <= btpc_pkg::TQ_W'(n9_in >>> 42) + btpc_pkg::TEMP_OFFSET;
         u5_ff   <= u5_in;
         // pressure divisor D and term E
         uu6_ff   <= u5_ff * u5_ff;
         pu2_6_ff <= u5_ff * $signed(calib.p2);
         pu5_6_ff <= u5_ff * $signed(calib.p5);
         a3_7_ff  <= uu6_ff * $signed(calib.p3);
         a6_7_ff  <= uu6_ff * $signed(calib.p6);
         pu2_7_ff <= pu2_6_ff;
         pu5_7_ff <= pu5_6_ff;
         dd8_ff   <= (btpc_pkg::POLY_W'(64'sd1) <<< 55) + btpc_pkg::POLY_W'(a3_7_ff)
                     + (btpc_pkg::POLY_W'(pu2_7_ff) <<< 20);
         e8_ff    <= btpc_pkg::POLY_W'(a6_7_ff) + (btpc_pkg::POLY_W'(pu5_7_ff) <<< 17)
                     + (btpc_pkg::POLY_W'($signed(calib.p4)) <<< 35);
         dd9_ff   <= dd8_ff;
         f9_ff    <= f9_in;
         // magnitudes and quotient sign
         fm10_ff  <= btpc_pkg::MAG_W'(f9_ff[btpc_pkg::POLY_W-1] ? -f9_ff : f9_ff);
         ddm10_ff <= btpc_pkg::MAG_W'(dd9_ff[btpc_pkg::POLY_W-1] ? -dd9_ff : dd9_ff);
         neg10_ff <= f9_ff[btpc_pkg::POLY_W-1] ^ dd9_ff[btpc_pkg::POLY_W-1];
         // wide products from the low 32 bits and the upper 29 bits
         pl11_ff   <= calib.p1 * ddm10_ff[31:0];
         ph11_ff   <= calib.p1 * ddm10_ff[btpc_pkg::MAG_W-1:32];
         nl11_ff   <= 45'(fm10_ff[31:0]) * 45'(btpc_pkg::PRES_SCALE);
         nh11_ff   <= 42'(fm10_ff[btpc_pkg::MAG_W-1:32]) * 42'(btpc_pkg::PRES_SCALE);
         zero11_ff <= (calib.p1 == '0) || (ddm10_ff == '0);
         neg11_ff  <= neg10_ff;
         den12_ff  <= (btpc_pkg::DEN_W'(ph11_ff) << 32) + btpc_pkg::DEN_W'(pl11_ff);
         nm12_ff   <= (btpc_pkg::NUM_W'(nh11_ff) << 32) + btpc_pkg::NUM_W'(nl11_ff);
         zero12_ff <= zero11_ff;
         neg12_ff  <= neg11_ff;
      end
   end

   always_comb begin
      push_data.temp  = temp_ff[12];
      push_data.tflag = tflag_ff[12];
      push_data.nm    = nm12_ff;
      push_data.den   = den12_ff;
      push_data.neg   = neg12_ff;
      push_data.zero  = zero12_ff;
   end

endmodule

FILE: rtl/btpc_queue.sv
// btpc_queue: small register queue between the front and back pipelines.
// Depends on btpc_pkg for the entry type.
module btpc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  btpc_pkg::front_rec_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output btpc_pkg::front_rec_type head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   btpc_pkg::front_rec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop) count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

FILE: rtl/btpc_div_stage.sv
// btpc_div_stage: one restoring-division step, one quotient bit per stage.
// Depends on btpc_pkg.
module btpc_div_stage #(
   parameter int SHIFT = 0
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [btpc_pkg::REM_W-1:0]   rem_in,
   input  logic [btpc_pkg::DEN_W-1:0]   den_in,
   input  logic [btpc_pkg::Q_W-1:0]     quo_in,
   input  btpc_pkg::side_type           side_in,
   output logic [btpc_pkg::REM_W-1:0]   rem_out,
   output logic [btpc_pkg::DEN_W-1:0]   den_out,
   output logic [btpc_pkg::Q_W-1:0]     quo_out,
   output btpc_pkg::side_type           side_out
);

   logic [btpc_pkg::REM_W:0]   diff;
   logic                       fits;
   logic [btpc_pkg::REM_W-1:0] rem_ff;
   logic [btpc_pkg::DEN_W-1:0] den_ff;
   logic [btpc_pkg::Q_W-1:0]   quo_ff;
   btpc_pkg::side_type         side_ff;

   assign diff = {1'b0, rem_in}
                 - ({{(btpc_pkg::REM_W + 1 - btpc_pkg::DEN_W){1'b0}}, den_in} << SHIFT);
   assign fits = !diff[btpc_pkg::REM_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= fits ? diff[btpc_pkg::REM_W-1:0] : rem_in;
         quo_ff  <= fits ? (quo_in | (btpc_pkg::Q_W'(1) << SHIFT)) : quo_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign quo_out  = quo_ff;
   assign side_out = side_ff;

endmodule

FILE: rtl/btpc_back.sv
// btpc_back: back pipeline. Overflow check, 47-stage divider, final pressure
// polynomial, saturation and the result register. Depends on btpc_pkg and
// btpc_div_stage.
module btpc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  btpc_pkg::calib_type                 calib,
   input  logic                                head_valid,
   input  btpc_pkg::front_rec_type             head_data,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [btpc_pkg::TEMP_W-1:0]  rsp_temperature_centi_f,
   output logic [btpc_pkg::PRES_W-1:0]         rsp_pressure_q8,
   output logic                                rsp_result_flag
);

   // load, overflow check, divider steps, six polynomial stages, result
   localparam int STAGES = 2 + btpc_pkg::Q_W + 7;

   logic [STAGES-1:0] v_ff;
   logic              en;

   btpc_pkg::front_rec_type     rec0_ff;
   logic [btpc_pkg::REM_W-1:0]  rem1_ff;
   logic [btpc_pkg::DEN_W-1:0]  den1_ff;
   btpc_pkg::side_type          side1_ff;
   logic                        ovf1_in;

   logic [btpc_pkg::REM_W-1:0]  rem_c  [0:btpc_pkg::Q_W];
   logic [btpc_pkg::DEN_W-1:0]  den_c  [0:btpc_pkg::Q_W];
   logic [btpc_pkg::Q_W-1:0]    quo_c  [0:btpc_pkg::Q_W];
   btpc_pkg::side_type          side_c [0:btpc_pkg::Q_W];

   btpc_pkg::side_type          xside_ff [1:6];
   logic [btpc_pkg::Q_W-1:0]    qm1_in, qm1_ff;
   logic signed [btpc_pkg::QS_W-1:0] qs1_in;
   logic signed [btpc_pkg::QS_W-1:0] qs_ff [1:4];
   logic [45:0]                 hh2_ff;
   logic [46:0]                 hl2_ff;
   logic [47:0]                 ll2_ff;
   logic signed [63:0]          p8q_ff [2:4];
   logic [btpc_pkg::SQ_W-1:0]   sq3_ff;
   logic signed [63:0]          p9l4_ff, p9h4_ff;
   logic signed [btpc_pkg::Z_W-1:0] t9_5_ff, ta5_ff, tb5_ff, z6_ff;

   logic signed [btpc_pkg::TEMP_W-1:0] temp_ff;
   logic [btpc_pkg::PRES_W-1:0]        pres_ff, pres_in;
   logic                               flag_ff, flag_in;

   assign en  = !v_ff[STAGES-1] || rsp_ready;
   assign pop = en && head_valid;

   // quotient reaches 2^47 exactly when nm*2^40 >= den*2^47
   assign ovf1_in = {{(btpc_pkg::DEN_W + 7 - btpc_pkg::NUM_W){1'b0}}, rec0_ff.nm}
                    >= {rec0_ff.den, 7'b0000000};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], head_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rec0_ff        <= head_data;
         rem1_ff        <= btpc_pkg::REM_W'({rec0_ff.nm, {btpc_pkg::NUM_SHIFT{1'b0}}});
         den1_ff        <= rec0_ff.den;
         side1_ff.temp  <= rec0_ff.temp;
         side1_ff.tflag <= rec0_ff.tflag;
         side1_ff.neg   <= rec0_ff.neg;
         side1_ff.ovf   <= ovf1_in;
         side1_ff.zero  <= rec0_ff.zero;
      end
   end

   assign rem_c[0]  = rem1_ff;
   assign den_c[0]  = den1_ff;
   assign quo_c[0]  = '0;
   assign side_c[0] = side1_ff;

   for (genvar k = 0; k < btpc_pkg::Q_W; k++) begin : g_div
      btpc_div_stage #(
         .SHIFT (btpc_pkg::Q_W - 1 - k)
      ) u_stage (
         .clock    (clock),
         .enable   (en),
         .rem_in   (rem_c[k]),
         .den_in   (den_c[k]),
         .quo_in   (quo_c[k]),
         .side_in  (side_c[k]),
         .rem_out  (rem_c[k+1]),
         .den_out  (den_c[k+1]),
         .quo_out  (quo_c[k+1]),
         .side_out (side_c[k+1])
      );
   end

   assign qm1_in = side_c[btpc_pkg::Q_W].ovf ? btpc_pkg::Q_MAX : quo_c[btpc_pkg::Q_W];
   assign qs1_in = side_c[btpc_pkg::Q_W].neg ? -$signed({1'b0, qm1_in})
                                             : $signed({1'b0, qm1_in});

   always_ff @(posedge clock) begin
      if (en) begin
         xside_ff[1] <= side_c[btpc_pkg::Q_W];
         for (int i = 2; i <= 6; i++) xside_ff[i] <= xside_ff[i-1];
         qm1_ff   <= qm1_in;
         qs_ff[1] <= qs1_in;
         for (int i = 2; i <= 4; i++) qs_ff[i] <= qs_ff[i-1];
         // q^2 from a 23-bit upper and a 24-bit lower half of |q|
         hh2_ff    <= qm1_ff[46:24] * qm1_ff[46:24];
         hl2_ff    <= qm1_ff[46:24] * qm1_ff[23:0];
         ll2_ff    <= qm1_ff[23:0] * qm1_ff[23:0];
         p8q_ff[2] <= $signed(calib.p8) * qs_ff[1];
         p8q_ff[3] <= p8q_ff[2];
         p8q_ff[4] <= p8q_ff[3];
         sq3_ff    <= (btpc_pkg::SQ_W'(hh2_ff) << 48) + (btpc_pkg::SQ_W'(hl2_ff) << 25)
                      + btpc_pkg::SQ_W'(ll2_ff);
         p9l4_ff   <= $signed(calib.p9) * $signed({1'b0, sq3_ff[46:0]});
         p9h4_ff   <= $signed(calib.p9) * $signed({1'b0, sq3_ff[btpc_pkg::SQ_W-1:47]});
         t9_5_ff   <= (btpc_pkg::Z_W'(p9h4_ff) <<< 47) + btpc_pkg::Z_W'(p9l4_ff);
         ta5_ff    <= (btpc_pkg::Z_W'(qs_ff[4]) <<< 51) + (btpc_pkg::Z_W'(p8q_ff[4]) <<< 32);
         tb5_ff    <= (btpc_pkg::Z_W'($signed(calib.p7)) <<< 63) + btpc_pkg::Z_HALF;
         z6_ff     <= t9_5_ff + ta5_ff + tb5_ff;
         temp_ff   <= xside_ff[6].temp;
         pres_ff   <= pres_in;
         flag_ff   <= flag_in;
      end
   end

   always_comb begin
      pres_in = z6_ff[btpc_pkg::Z_SHIFT+btpc_pkg::PRES_W-1:btpc_pkg::Z_SHIFT];
      flag_in = xside_ff[6].tflag | xside_ff[6].ovf;
      if (xside_ff[6].zero) begin
         pres_in = '0;
         flag_in = 1'b1;
      end else if (z6_ff[btpc_pkg::Z_W-1]) begin
         pres_in = '0;
         flag_in = 1'b1;
      end else if (z6_ff[btpc_pkg::Z_W-2:btpc_pkg::Z_SHIFT+btpc_pkg::PRES_W] != '0) begin
         pres_in = btpc_pkg::PRES_MAX;
         flag_in = 1'b1;
      end
   end

   assign rsp_valid               = v_ff[STAGES-1];
   assign rsp_temperature_centi_f = temp_ff;
   assign rsp_pressure_q8         = pres_ff;
   assign rsp_result_flag         = flag_ff;

endmodule

FILE: rtl/baro_temp_pressure_compensation_unit.sv
// Barometric pressure/temperature compensation unit (top level).
// Uses btpc_pkg, btpc_front, btpc_queue and btpc_back.
//
// Usage:
//   - Load the four calibration registers over the csr_ port (csr_we,
//     csr_index, csr_wdata) while no reading is in flight. Reset clears them.
//   - Each req_ transfer carries one raw pressure and one raw temperature
//     reading; each rsp_ transfer returns temperature in 0.01 degF, pressure
//     in Pa (Q8) and a flag for saturation, quotient overflow or a zero
//     divisor.
//   - Throughput: one reading per cycle while rsp_ready stays high. Every
//     step of the polynomials and of the division has a stage of its own.
//   - Path: a reading passes 12 front stages (the first is loaded at the
//     accepting edge), one queue entry and 56 back stages (of which 47 are
//     the one-bit-per-stage divider), then rsp_valid rises.
//   - Back-pressure: when rsp_ready is low the back pipeline holds; the
//     front keeps accepting until the queue (QUEUE_DEPTH entries) fills,
//     then req_ready drops. Nothing is lost or repeated.
//   - Reset (synchronous) empties both pipelines and the queue.
module baro_temp_pressure_compensation_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [btpc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [btpc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // readings in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [btpc_pkg::RAW_W-1:0]           req_raw_pressure,
   input  logic [btpc_pkg::RAW_W-1:0]           req_raw_temperature,
   // results out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [btpc_pkg::TEMP_W-1:0]   rsp_temperature_centi_f,
   output logic [btpc_pkg::PRES_W-1:0]          rsp_pressure_q8,
   output logic                                 rsp_result_flag
);

   logic [47:0] calib_temp_ff;
   logic [63:0] calib_press_a_ff;
   logic [63:0] calib_press_b_ff;
   logic [15:0] calib_press_c_ff;

   btpc_pkg::calib_type     calib;
   btpc_pkg::front_rec_type push_data, head_data;
   logic                    push, pop, queue_full, head_valid;

   // calibration registers; wider write data is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_temp_ff    <= '0;
         calib_press_a_ff <= '0;
         calib_press_b_ff <= '0;
         calib_press_c_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            btpc_pkg::CSR_CALIB_TEMP:    calib_temp_ff    <= csr_wdata[47:0];
            btpc_pkg::CSR_CALIB_PRESS_A: calib_press_a_ff <= csr_wdata;
            btpc_pkg::CSR_CALIB_PRESS_B: calib_press_b_ff <= csr_wdata;
            btpc_pkg::CSR_CALIB_PRESS_C: calib_press_c_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // unpack the twelve calibration words
   always_comb begin
      calib.t1 = calib_temp_ff[15:0];
      calib.t2 = calib_temp_ff[31:16];
      calib.t3 = calib_temp_ff[47:32];
      calib.p1 = calib_press_a_ff[15:0];
      calib.p2 = calib_press_a_ff[31:16];
      calib.p3 = calib_press_a_ff[47:32];
      calib.p4 = calib_press_a_ff[63:48];
      calib.p5 = calib_press_b_ff[15:0];
      calib.p6 = calib_press_b_ff[31:16];
      calib.p7 = calib_press_b_ff[47:32];
      calib.p8 = calib_press_b_ff[63:48];
      calib.p9 = calib_press_c_ff;
   end

   btpc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .calib               (calib),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .queue_full          (queue_full),
      .push                (push),
      .push_data           (push_data)
   );

   btpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   btpc_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .calib                   (calib),
      .head_valid              (head_valid),
      .head_data               (head_data),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_temperature_centi_f (rsp_temperature_centi_f),
      .rsp_pressure_q8         (rsp_pressure_q8),
      .rsp_result_flag         (rsp_result_flag)
   );

endmodule
